>>> hw/rtl/hashed_block_cache_lru_core_assert.svh
// Assertion macros for the hashed block cache core.
// Included by the top level only; no other dependencies.
`ifndef HASHED_BLOCK_CACHE_LRU_CORE_ASSERT_SVH
`define HASHED_BLOCK_CACHE_LRU_CORE_ASSERT_SVH
// check that a condition implies a consequence on the same edge
`define HBC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("hbc check failed");
// check that a condition implies a consequence on the next edge
`define HBC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("hbc check failed");
`endif

>>> hw/rtl/hbc_pkg.sv
// Package for the hashed block cache core: sizes, codes and entry record.
// No dependencies.
package hbc_pkg;
  localparam int Entries = 32;
  localparam int Buckets = 13;
  localparam int IdxW = $clog2(Entries);
  localparam int CntW = $clog2(Entries + 1);
  localparam logic [7:0] RefsMax = 8'd255;
  localparam logic [12:0] BucketRecip = 13'd5042;

  typedef enum logic [1:0] {
    KIND_GET = 2'd0, KIND_RELEASE = 2'd1, KIND_PIN = 2'd2, KIND_UNPIN = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_NO_FREE = 2'd1, ST_REF_ERR = 2'd2
  } status_t;

  typedef struct packed {
    logic [7:0]  device;
    logic [31:0] block;
    logic        valid;
    logic [7:0]  refs;
    logic [31:0] last_use;
    logic [3:0]  bucket;
    logic [31:0] order;
  } entry_t;

  typedef struct packed {
    logic         we;
    logic [IdxW-1:0] addr;
    entry_t       data;
  } mem_wr_t;

  typedef enum logic [2:0] {
    S_IDLE, S_HASH, S_HSCAN, S_FSCAN, S_WRITE, S_OUT
  } state_t;
endpackage

>>> hw/rtl/hashed_block_cache_lru_core.sv
// Hashed disk block cache directory with LRU replacement, top level.
// Uses hbc_pkg, hbc_dir_mem, hbc_mod13 and the assertion macro header.
//
// Requests come in on kind/device/block_number/entry_index/time_now with
// in_valid/in_ready; one result per request leaves on entry_out/hit/
// read_needed/status with out_valid/out_ready. One request is worked on at
// a time. Release, pin and unpin read the addressed entry, modify it and
// write it back. A get hashes the block number, then sweeps the directory
// once for a hit, and on a miss once per bucket tried, up to 13; each
// sweep reads the entries one by one through the single read port of
// the directory memory. The result register holds while out_ready is low;
// in_ready stays low until the result is taken. Reset empties the
// directory at once: each entry reads as zero, bucket zero, insertion
// order equal to its index.
module hashed_block_cache_lru_core import hbc_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [7:0]  device,
  input  logic [31:0] block_number,
  input  logic [4:0]  entry_index,
  input  logic [31:0] time_now,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  entry_out,
  output logic        hit,
  output logic        read_needed,
  output logic [1:0]  status
);
`include "hashed_block_cache_lru_core_assert.svh"

  state_t state, state_next;
  kind_t   r_kind;
  logic [7:0]  r_dev;
  logic [31:0] r_blk, r_now, next_order;
  logic [4:0]  r_idx;
  logic [3:0]  home, bkt, tries;
  logic [CntW-1:0] cnt;
  logic [IdxW-1:0] raddr, sel;
  logic        found, pend, pend_d;
  logic [IdxW-1:0] pidx;
  entry_t      rd, best;
  mem_wr_t     wr;
  logic        h_start, h_done;
  logic [3:0]  h_rem;
  logic        acc;

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign acc = in_valid && in_ready;

  hbc_dir_mem u_mem (.clk, .rst, .raddr, .rdata(rd), .wr);
  hbc_mod13 u_hash (.clk, .start(h_start), .value(block_number), .rem(h_rem),
                    .done(h_done));

  // sweep: address cnt issued, data for pidx valid when pend_d
  always_comb begin
    if (state == S_HSCAN || state == S_FSCAN) raddr = cnt[IdxW-1:0];
    else if (state == S_IDLE) raddr = entry_index[IdxW-1:0];
    else raddr = r_idx[IdxW-1:0];
  end

  logic cand, better;
  always_comb begin
    cand = 1'b0;
    better = 1'b0;
    if (state == S_HSCAN) begin
      cand = rd.bucket == home && rd.device == r_dev && rd.block == r_blk;
      better = !found || rd.order > best.order;
    end else begin
      cand = rd.bucket == bkt && rd.refs == 8'd0;
      better = !found || rd.last_use < best.last_use ||
               (rd.last_use == best.last_use && rd.order > best.order);
    end
  end

  logic sweep_end;
  assign sweep_end = pend_d && !pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      next_order <= 32'(Entries);
      pend <= 1'b0;
      pend_d <= 1'b0;
    end else begin
      state <= state_next;
      pend_d <= pend;
      if (acc) begin
        r_kind <= kind_t'(kind);
        r_dev <= device;
        r_blk <= block_number;
        r_idx <= entry_index;
        r_now <= time_now;
      end
      if (state == S_HASH && h_done) begin
        home <= h_rem;
        bkt <= h_rem;
        tries <= '0;
        cnt <= '0;
        pend <= 1'b1;
        found <= 1'b0;
      end
      if (state == S_HSCAN || state == S_FSCAN) begin
        if (pend) begin
          pidx <= cnt[IdxW-1:0];
          if (cnt == CntW'(Entries - 1)) pend <= 1'b0;
          else cnt <= cnt + CntW'(1);
        end
        if (pend_d && cand && better) begin
          found <= 1'b1;
          best <= rd;
          sel <= pidx;
        end
        if (sweep_end) begin
          cnt <= '0;
          if (!(found || (pend_d && cand && better)) &&
              !(state == S_FSCAN && tries == 4'(Buckets - 1))) pend <= 1'b1;
          if (state == S_HSCAN) begin
            if (!(found || (cand && better))) found <= 1'b0;
          end else if (!(found || (cand && better))) begin
            bkt <= (bkt == 4'(Buckets - 1)) ? 4'd0 : bkt + 4'd1;
            tries <= tries + 4'd1;
          end
        end
      end
      if (wr.we && state == S_WRITE && r_kind == KIND_GET && !hit &&
          best.bucket != home && status == ST_OK)
        next_order <= next_order + 32'd1;
      if (state == S_WRITE) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end

  // result and write-back, computed in S_WRITE
  entry_t e;
  always_comb begin
    e = rd;
    wr = '0;
    if (state == S_WRITE) begin
      if (r_kind == KIND_GET) begin
        e = best;
        if (hit) begin
          if (best.refs != RefsMax) e.refs = best.refs + 8'd1;
          e.last_use = r_now;
          e.valid = 1'b1;
          wr.we = 1'b1;
        end else if (status == ST_OK) begin
          if (best.bucket != home) begin
            e.bucket = home;
            e.order = next_order;
          end
          e.device = r_dev;
          e.block = r_blk;
          e.refs = 8'd1;
          e.last_use = r_now;
          e.valid = 1'b1;
          wr.we = 1'b1;
        end
        wr.addr = sel;
      end else begin
        wr.addr = r_idx[IdxW-1:0];
        if (status == ST_OK) begin
          wr.we = 1'b1;
          if (r_kind == KIND_PIN) e.refs = rd.refs + 8'd1;
          else e.refs = rd.refs - 8'd1;
          if (r_kind == KIND_RELEASE) e.last_use = r_now;
        end
      end
      wr.data = e;
    end
  end

  // result fields latched as the decision is made
  always_ff @(posedge clk) begin
    if (state == S_HSCAN && sweep_end) begin
      hit <= found || (cand && better);
    end
    if (state_next == S_WRITE && state != S_WRITE) begin
      if (r_kind == KIND_GET) begin
        if (state == S_HSCAN) begin
          entry_out <= 5'(found && !(cand && better) ? sel : pidx);
          read_needed <= found && !(cand && better) ? !best.valid : !rd.valid;
          status <= (found && !(cand && better) ? best.refs : rd.refs) == RefsMax
                    ? ST_REF_ERR : ST_OK;
        end else if (found || (pend_d && cand && better)) begin
          entry_out <= 5'(found && !(cand && better) ? sel : pidx);
          read_needed <= 1'b1;
          status <= ST_OK;
        end else begin
          entry_out <= '0;
          read_needed <= 1'b0;
          status <= ST_NO_FREE;
        end
      end else begin
        entry_out <= r_idx;
        read_needed <= 1'b0;
        hit <= 1'b0;
        if (r_kind == KIND_PIN) status <= (rd.refs == RefsMax) ? ST_REF_ERR : ST_OK;
        else status <= (rd.refs == 8'd0) ? ST_REF_ERR : ST_OK;
      end
    end
    if (state == S_FSCAN && state_next == S_WRITE) hit <= 1'b0;
  end

  always_comb begin
    state_next = state;
    h_start = 1'b0;
    unique case (state)
      S_IDLE: if (acc) begin
        state_next = (kind_t'(kind) == KIND_GET) ? S_HASH : S_OUT;
        h_start = (kind_t'(kind) == KIND_GET);
      end
      S_OUT: state_next = S_WRITE; // read of the addressed entry settles
      S_HASH: if (h_done) state_next = S_HSCAN;
      S_HSCAN: if (sweep_end)
        state_next = (found || (cand && better)) ? S_WRITE : S_FSCAN;
      S_FSCAN: if (sweep_end) begin
        if (found || (cand && better)) state_next = S_WRITE;
        else if (tries == 4'(Buckets - 1)) state_next = S_WRITE;
      end
      S_WRITE: state_next = (out_valid && !out_ready) ? S_WRITE : S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  `HBC_ASSERT_IMP(a_busy_not_ready, state != S_IDLE, !in_ready)
  `HBC_ASSERT_NXT(a_write_gives_result, state == S_WRITE && !out_valid, out_valid)
  `HBC_ASSERT_IMP(a_no_free_clean, out_valid && status == ST_NO_FREE,
                  !hit && !read_needed && entry_out == 5'd0)
endmodule

>>> hw/rtl/hbc_dir_mem.sv
// Directory memory of the hashed block cache: one entry record per line.
// Depends on hbc_pkg. Entries not yet written read as their reset value.
module hbc_dir_mem import hbc_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic [IdxW-1:0] raddr,
  output entry_t          rdata,
  input  mem_wr_t         wr
);
  entry_t mem [Entries];
  logic [Entries-1:0] written;
  logic [IdxW-1:0] raddr_q;
  entry_t mdata;

  always_ff @(posedge clk) begin
    if (wr.we) mem[wr.addr] <= wr.data;
    mdata <= mem[raddr];
    raddr_q <= raddr;
  end

  always_ff @(posedge clk) begin
    if (rst) written <= '0;
    else if (wr.we) written[wr.addr] <= 1'b1;
  end

  always_comb begin
    if (written[raddr_q]) rdata = mdata;
    else begin
      rdata = '0;
      rdata.order = 32'(raddr_q);
    end
  end
endmodule

>>> hw/rtl/hbc_mod13.sv
// Remainder of a block number by the bucket count, in registered steps:
// fold 12-bit digits (2^12 is 1 modulo 13), then multiply by the reciprocal.
// Depends on hbc_pkg.
module hbc_mod13 import hbc_pkg::*; (
  input  logic        clk,
  input  logic        start,
  input  logic [31:0] value,
  output logic [3:0]  rem,
  output logic        done
);
  logic [13:0] s1;
  logic [12:0] s2;
  logic [1:0]  stage;
  logic [25:0] prod;
  logic [12:0] q;

  assign prod = 26'(s2) * 26'(BucketRecip);
  assign q = 13'(prod >> 16);
  assign done = (stage == 2'd3);

  always_ff @(posedge clk) begin
    if (start) begin
      s1 <= 14'(value[11:0]) + 14'(value[23:12]) + 14'(value[31:24]);
      stage <= 2'd1;
    end else if (stage == 2'd1) begin
      s2 <= 13'(s1[11:0]) + 13'(s1[13:12]);
      stage <= 2'd2;
    end else if (stage == 2'd2) begin
      rem <= 4'(s2 - 13'(q * 13'(Buckets)));
      stage <= 2'd3;
    end
  end
endmodule

>>> dv/hashed_block_cache_lru_core_test.sv
// Self-checking test of the hashed block cache directory core.
// Depends on hbc_pkg and hashed_block_cache_lru_core; drives requests, predicts results.
module hashed_block_cache_lru_core_test import hbc_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [4:0] entry;
    logic       hit;
    logic       rd;
    status_t    st;
  } answer_t;

  typedef struct {
    kind_t       k;
    logic [7:0]  dev;
    logic [31:0] blk;
    logic [4:0]  idx;
    logic [31:0] now;
    bit          typed;
    answer_t     ans;
  } row_t;

  logic        clk, rst;
  logic        in_valid, in_ready, out_valid, out_ready;
  logic [1:0]  kind;
  logic [7:0]  device;
  logic [31:0] block_number;
  logic [4:0]  entry_index;
  logic [31:0] time_now;
  logic [4:0]  entry_out;
  logic        hit, read_needed;
  logic [1:0]  status;

  hashed_block_cache_lru_core DUT (.*);

  logic [7:0]  c_dev [Entries];
  logic [31:0] c_blk [Entries];
  logic        c_val [Entries];
  logic [7:0]  c_refs [Entries];
  logic [31:0] c_use [Entries];
  logic [3:0]  c_bkt [Entries];
  logic [31:0] c_ord [Entries];
  logic [31:0] ord_next;

  answer_t awaited[$];
  int      mismatches = 0;
  bit      quiet = 0;
  bit      long_hold = 0;
  row_t    rows[$];

  function automatic answer_t cache_lookup(kind_t k, logic [7:0] dev, logic [31:0] blk,
                                           logic [4:0] idx, logic [31:0] now);
    answer_t a;
    int found, pick;
    logic [3:0] home, b;
    a = '{entry: idx, hit: 0, rd: 0, st: ST_OK};
    if (k == KIND_GET) begin
      home = blk % Buckets;
      found = -1;
      for (int i = 0; i < Entries; i++)
        if (c_bkt[i] == home && c_dev[i] == dev && c_blk[i] == blk &&
            (found < 0 || c_ord[i] > c_ord[found])) found = i;
      if (found >= 0) begin
        if (c_refs[found] == RefsMax) a.st = ST_REF_ERR;
        else c_refs[found]++;
        c_use[found] = now;
        a.rd = !c_val[found];
        c_val[found] = 1;
        a.entry = found;
        a.hit = 1;
        return a;
      end
      for (int c = 0; c < Buckets; c++) begin
        b = (home + c) % Buckets;
        pick = -1;
        for (int i = 0; i < Entries; i++) begin
          if (c_bkt[i] != b || c_refs[i] != 0) continue;
          if (pick < 0 || c_use[i] < c_use[pick] ||
              (c_use[i] == c_use[pick] && c_ord[i] > c_ord[pick])) pick = i;
        end
        if (pick >= 0) begin
          if (b != home) begin
            c_bkt[pick] = home;
            c_ord[pick] = ord_next;
            ord_next++;
          end
          c_dev[pick] = dev;
          c_blk[pick] = blk;
          c_refs[pick] = 1;
          c_use[pick] = now;
          c_val[pick] = 1;
          return '{entry: pick, hit: 0, rd: 1, st: ST_OK};
        end
      end
      return '{entry: 0, hit: 0, rd: 0, st: ST_NO_FREE};
    end
    if (k == KIND_PIN) begin
      if (c_refs[idx] == RefsMax) a.st = ST_REF_ERR;
      else c_refs[idx]++;
    end else if (c_refs[idx] == 0) begin
      a.st = ST_REF_ERR;
    end else begin
      c_refs[idx]--;
      if (k == KIND_RELEASE) c_use[idx] = now;
    end
    return a;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("tb: failure");
    $finish;
  end

  // result side
  initial begin
    int gap;
    out_ready = 0;
    @(negedge rst);
    forever begin
      @(negedge clk);
      if (long_hold) begin
        out_ready <= 0;
        repeat (400) @(negedge clk);
        long_hold = 0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        gap = $urandom_range(1, 7);
        out_ready <= 0;
        repeat (gap - 1) @(negedge clk);
      end else begin
        out_ready <= 1;
      end
    end
  end

  always @(posedge clk) begin
    answer_t got, want;
    if (!rst && out_valid && out_ready) begin
      got = '{entry: entry_out, hit: hit, rd: read_needed, st: status_t'(status)};
      if (awaited.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
      end else begin
        want = awaited.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  task automatic send(row_t r);
    answer_t a;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    in_valid <= 1;
    kind <= r.k;
    device <= r.dev;
    block_number <= r.blk;
    entry_index <= r.idx;
    time_now <= r.now;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    a = cache_lookup(r.k, r.dev, r.blk, r.idx, r.now);
    if (r.typed && a !== r.ans) begin
      mismatches++;
      if (mismatches <= 10) $display("table row disagrees: %p vs %p", r.ans, a);
    end
    awaited.push_back(r.typed ? r.ans : a);
    @(negedge clk);
  endtask

  function automatic row_t mk(kind_t k, logic [7:0] d, logic [31:0] b, logic [4:0] i,
                              logic [31:0] t);
    return '{k: k, dev: d, blk: b, idx: i, now: t, typed: 0, ans: '0};
  endfunction

  function automatic row_t mkt(kind_t k, logic [7:0] d, logic [31:0] b, logic [4:0] i,
                               logic [31:0] t, answer_t a);
    row_t r;
    r = mk(k, d, b, i, t);
    r.typed = 1;
    r.ans = a;
    return r;
  endfunction

  initial begin
    row_t r;
    int waited;
    logic [31:0] clock_ticks;
    for (int i = 0; i < Entries; i++) begin
      c_dev[i] = 0; c_blk[i] = 0; c_val[i] = 0; c_refs[i] = 0;
      c_use[i] = 0; c_bkt[i] = 0; c_ord[i] = i;
    end
    ord_next = Entries;
    rst = 1;
    in_valid = 0; kind = KIND_GET; device = 0; block_number = 0;
    entry_index = 0; time_now = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    rows.push_back(mkt(KIND_GET, 0, 0, 0, 5, '{31, 1, 1, ST_OK}));
    rows.push_back(mkt(KIND_UNPIN, 0, 0, 3, 0, '{3, 0, 0, ST_REF_ERR}));
    rows.push_back(mkt(KIND_RELEASE, 0, 0, 4, 0, '{4, 0, 0, ST_REF_ERR}));
    rows.push_back(mkt(KIND_RELEASE, 0, 0, 31, 9, '{31, 0, 0, ST_OK}));
    rows.push_back(mk(KIND_GET, 8'hff, 32'hffff_ffff, 0, 32'hffff_ffff));
    rows.push_back(mk(KIND_GET, 8'h00, 32'd13, 0, 0));
    rows.push_back(mk(KIND_GET, 8'h00, 32'd13, 0, 1));
    rows.push_back(mk(KIND_PIN, 0, 0, 31, 0));
    rows.push_back(mk(KIND_UNPIN, 0, 0, 31, 0));
    rows.push_back(mk(KIND_GET, 8'h5a, 32'h8000_0000, 0, 7));
    rows.push_back(mk(KIND_RELEASE, 0, 0, 0, 32'hffff_ffff));
    foreach (rows[i]) send(rows[i]);

    // pin one entry to saturation and past it, get a block, then unpin it again
    for (int n = 0; n < 256; n++) send(mk(KIND_PIN, 0, 0, 2, 0));
    send(mk(KIND_GET, c_dev[2], c_blk[2], 0, 3));
    for (int n = 0; n < 256; n++) send(mk(KIND_UNPIN, 0, 0, 2, 0));

    // fill every entry, ask again for no free entry, with the result side stalled at the start
    long_hold = 1;
    for (int n = 0; n < 34; n++) send(mk(KIND_GET, $urandom, $urandom, 0, n));
    for (int i = 0; i < Entries; i++)
      while (c_refs[i] != 0) send(mk(KIND_RELEASE, 0, 0, i, $urandom));

    clock_ticks = 100;
    for (int n = 0; n < 1260; n++) begin
      r = mk(kind_t'($urandom_range(0, 3)), $urandom_range(0, 3),
             $urandom_range(0, 40), $urandom_range(0, 31), clock_ticks);
      if ($urandom_range(0, 9) == 0) begin
        r.dev = $urandom;
        r.blk = $urandom;
        r.now = $urandom;
      end
      if (r.k != KIND_GET && $urandom_range(0, 2) != 0) begin
        for (int i = 0; i < Entries; i++)
          if (c_refs[i] != 0 && $urandom_range(0, 3) == 0) r.idx = i;
      end
      clock_ticks += $urandom_range(0, 3);
      if (n >= 1110) quiet = 1;
      send(r);
    end
    in_valid <= 0;

    waited = 0;
    while (awaited.size() != 0 && waited < 100000) begin
      @(posedge clk);
      waited++;
    end
    repeat (50) @(posedge clk);
    if (mismatches == 0 && awaited.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/hbc_pkg.sv
hw/rtl/hbc_dir_mem.sv
hw/rtl/hbc_mod13.sv
hw/rtl/hashed_block_cache_lru_core.sv
dv/hashed_block_cache_lru_core_test.sv
